// ===== hw/rtl/sbc_pkg.sv =====
// package: opcodes, fault codes and sizes for the stack bytecode core
`default_nettype none
package sbc_pkg;
	localparam int STACK_DEPTH_D = 256;
	localparam int CALL_DEPTH_D  = 32;
	localparam int PC_WIDTH_D    = 16;
	localparam int LEN_W         = 16;
	localparam int WORD_W        = 32;

	localparam logic [4:0] OP_SHIFT = 5'd0;
	localparam logic [4:0] OP_PUSH  = 5'd1;
	localparam logic [4:0] OP_LOAD  = 5'd2;
	localparam logic [4:0] OP_STORE = 5'd3;
	localparam logic [4:0] OP_ADD   = 5'd4;
	localparam logic [4:0] OP_SUB   = 5'd5;
	localparam logic [4:0] OP_MUL   = 5'd6;
	localparam logic [4:0] OP_DIV   = 5'd7;
	localparam logic [4:0] OP_MOD   = 5'd8;
	localparam logic [4:0] OP_EQ    = 5'd9;
	localparam logic [4:0] OP_NEQ   = 5'd10;
	localparam logic [4:0] OP_GT    = 5'd11;
	localparam logic [4:0] OP_LT    = 5'd12;
	localparam logic [4:0] OP_GE    = 5'd13;
	localparam logic [4:0] OP_LE    = 5'd14;
	localparam logic [4:0] OP_AND   = 5'd15;
	localparam logic [4:0] OP_OR    = 5'd16;
	localparam logic [4:0] OP_NOT   = 5'd17;
	localparam logic [4:0] OP_GOTO  = 5'd18;
	localparam logic [4:0] OP_CALL  = 5'd19;
	localparam logic [4:0] OP_GOTOIF = 5'd20;
	localparam logic [4:0] OP_PRINTI = 5'd21;
	localparam logic [4:0] OP_PRINTB = 5'd22;
	localparam logic [4:0] OP_PRINTS = 5'd23;
	localparam logic [4:0] OP_RESUME = 5'd24;
	localparam logic [4:0] OP_RETURN = 5'd25;
	localparam logic [4:0] OP_END   = 5'd26;

	localparam logic [2:0] FLT_NONE  = 3'd0;
	localparam logic [2:0] FLT_ILL   = 3'd1;
	localparam logic [2:0] FLT_OVER  = 3'd2;
	localparam logic [2:0] FLT_UNDER = 3'd3;
	localparam logic [2:0] FLT_DIV0  = 3'd4;
	localparam logic [2:0] FLT_CALL  = 3'd5;

	typedef struct packed {
		logic        start;
		logic        is_mod;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] result;
	} div_rsp_t;
endpackage
`default_nettype wire

// ===== hw/rtl/sbc_divider.sv =====
// radix-2 restoring signed divider, one quotient bit per cycle
`default_nettype none
module sbc_divider
	import sbc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);
	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [31:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dsr_q;
	logic        neg_q_q;
	logic        neg_r_q;
	logic        mod_q;
	logic        done_q;
	logic [32:0] shifted;
	logic [32:0] diff;
	logic [31:0] qres;
	logic [31:0] rres;

	assign shifted = {rem_q[31:0], quo_q[31]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign qres    = neg_q_q ? (32'd0 - quo_q) : quo_q;
	assign rres    = neg_r_q ? (32'd0 - rem_q[31:0]) : rem_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q   <= req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
			dsr_q   <= req.divisor[31] ? (32'd0 - req.divisor) : req.divisor;
			rem_q   <= '0;
			neg_q_q <= req.dividend[31] ^ req.divisor[31];
			neg_r_q <= req.dividend[31];
			mod_q   <= req.is_mod;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = mod_q ? rres : qres;

	chk_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while busy");
	chk_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q && !req.start |=> !done_q || $past(busy_q))
		else $error("divider done without run");
	chk_start: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q && cnt_q == 6'd0)
		else $error("divider did not start");
endmodule
`default_nettype wire

// ===== hw/rtl/sbc_call_stack.sv =====
// call stack memory: return address and saved stack mark per frame
`default_nettype none
module sbc_call_stack
	import sbc_pkg::*;
#(
	parameter int CALL_DEPTH = CALL_DEPTH_D,
	parameter int PC_WIDTH   = PC_WIDTH_D,
	parameter int SP_W       = 9
)
(
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [$clog2(CALL_DEPTH)-1:0] waddr,
	input  wire logic [PC_WIDTH-1:0]           wret,
	input  wire logic [SP_W-1:0]               wmark,
	input  wire logic [$clog2(CALL_DEPTH)-1:0] raddr,
	output logic      [PC_WIDTH-1:0]           rret,
	output logic      [SP_W-1:0]               rmark
);
	logic [PC_WIDTH+SP_W-1:0] mem [CALL_DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= {wret, wmark};
		{rret, rmark} <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/sbc_data_stack.sv =====
// data stack memory, one write and one registered read port
`default_nettype none
module sbc_data_stack
	import sbc_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_D
)
(
	input  wire logic                           clk,
	input  wire logic                           we,
	input  wire logic [$clog2(STACK_DEPTH)-1:0] waddr,
	input  wire logic [WORD_W-1:0]              wdata,
	input  wire logic [$clog2(STACK_DEPTH)-1:0] raddr,
	output logic      [WORD_W-1:0]              rdata
);
	logic [WORD_W-1:0] mem [STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/stack_bytecode_core.sv =====
// top level: stack bytecode interpreter core with sequencer
// Usage
//   Instruction channel: in_valid/in_stall with func and argument, one
//   instruction per beat. Result channel: out_valid/out_stall with next_pc,
//   print fields, halted and fault_code, one result beat per instruction.
//   Config channel: cfg_valid/cfg_ready writes program_length; write only
//   while idle.
// Sequence: for every executed instruction the core reads the top of stack
//   while idle, reads the second word, then executes and writes back; a step
//   taken while halted goes straight to the output state; divide and mod wait
//   in a divide state for the bit-serial divider and then execute. One
//   instruction is in flight at a time; the next is taken once its result
//   beat has been loaded into the output register.
// Reset clears counter, stack pointer, call depth, halt and fault; stack
//   contents are undefined until written.
// A stalled result holds in the output register; the next instruction is
//   taken meanwhile and its result waits until the register is free.
`default_nettype none
module stack_bytecode_core
	import sbc_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_D,
	parameter int CALL_DEPTH  = CALL_DEPTH_D,
	parameter int PC_WIDTH    = PC_WIDTH_D
)
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [4:0]         func,
	input  wire logic signed [31:0] argument,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [15:0]             next_pc,
	output logic                    print_valid,
	output logic [1:0]              print_kind,
	output logic signed [31:0]      print_value,
	output logic                    halted,
	output logic [2:0]              fault_code,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [15:0]        cfg_data
);
	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam int SA_W = $clog2(STACK_DEPTH);
	localparam int CD_W = $clog2(CALL_DEPTH + 1);
	localparam int CA_W = $clog2(CALL_DEPTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD1  = 3'd1;
	localparam logic [2:0] ST_RD2  = 3'd2;
	localparam logic [2:0] ST_EXE  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]          state_q;
	logic [4:0]          op_q;
	logic [31:0]         arg_q;
	logic [SP_W-1:0]     sp_q;
	logic [CD_W-1:0]     cd_q;
	logic [PC_WIDTH-1:0] pc_q;
	logic                halt_q;
	logic [2:0]          fault_q;
	logic [LEN_W-1:0]    len_q;
	logic [31:0]         top_q;
	logic [31:0]         sec_q;

	logic                ovalid_q;
	logic [15:0]         onpc_q;
	logic                opv_q;
	logic [1:0]          opk_q;
	logic [31:0]         opval_q;
	logic                ohalt_q;
	logic [2:0]          ofault_q;

	logic                ds_we;
	logic [SA_W-1:0]     ds_waddr;
	logic [31:0]         ds_wdata;
	logic [SA_W-1:0]     ds_raddr;
	logic [31:0]         ds_rdata;
	logic                cs_we;
	logic [CA_W-1:0]     cs_waddr;
	logic [CA_W-1:0]     cs_raddr;
	logic [PC_WIDTH-1:0] cs_rret;
	logic [SP_W-1:0]     cs_rmark;
	div_req_t            dreq;
	div_rsp_t            drsp;

	logic [PC_WIDTH-1:0] pc_next1;
	logic [PC_WIDTH-1:0] target;
	logic signed [33:0]  sp_s;
	logic signed [33:0]  arg_s;
	logic signed [33:0]  idx_load;
	logic signed [33:0]  idx_store;
	logic signed [33:0]  nsp;
	logic                in_acc;
	logic                out_free;
	logic                out_load;

	// execute results
	logic [2:0]          x_fault;
	logic [SP_W-1:0]     x_sp;
	logic [CD_W-1:0]     x_cd;
	logic [PC_WIDTH-1:0] x_next;
	logic                x_pv;
	logic [1:0]          x_pk;
	logic                x_end;
	logic                x_we;
	logic [SA_W-1:0]     x_waddr;
	logic [31:0]         x_wdata;
	logic                x_cwe;
	logic [31:0]         alu;
	logic signed [31:0]  ls;
	logic signed [31:0]  rs;

	sbc_data_stack #(.STACK_DEPTH(STACK_DEPTH)) u_ds (
		.clk(clk), .we(ds_we), .waddr(ds_waddr), .wdata(ds_wdata),
		.raddr(ds_raddr), .rdata(ds_rdata)
	);

	sbc_call_stack #(.CALL_DEPTH(CALL_DEPTH), .PC_WIDTH(PC_WIDTH), .SP_W(SP_W)) u_cs (
		.clk(clk), .we(cs_we), .waddr(cs_waddr), .wret(pc_next1),
		.wmark(sp_q), .raddr(cs_raddr), .rret(cs_rret), .rmark(cs_rmark)
	);

	sbc_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign out_free  = !ovalid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_load  = out_free && ((state_q == ST_EXE && !dreq.start) || state_q == ST_OUT);

	assign pc_next1  = pc_q + {{(PC_WIDTH-1){1'b0}}, 1'b1};
	assign target    = arg_q[PC_WIDTH-1:0];
	assign sp_s      = 34'(sp_q);
	assign arg_s     = 34'(signed'(arg_q));
	assign idx_load  = sp_s - arg_s - 34'sd1;
	assign idx_store = sp_s - 34'sd1 - arg_s;
	assign nsp       = 34'(cs_rmark) - arg_s;
	assign ls        = signed'(sec_q);
	assign rs        = signed'(top_q);

	// read addresses: top while idle, second / load slot in RD1
	always_comb begin
		ds_raddr = SA_W'(sp_q - SP_W'(1));
		if (state_q == ST_RD1) begin
			if (op_q == OP_LOAD)
				ds_raddr = idx_load[SA_W-1:0];
			else
				ds_raddr = SA_W'(sp_q - SP_W'(2));
		end
	end
	assign cs_raddr = CA_W'(cd_q - CD_W'(1));

	always_comb begin
		case (op_q)
			OP_ADD:  alu = sec_q + top_q;
			OP_SUB:  alu = sec_q - top_q;
			OP_MUL:  alu = sec_q * top_q;
			OP_EQ:   alu = {31'd0, ls == rs};
			OP_NEQ:  alu = {31'd0, ls != rs};
			OP_GT:   alu = {31'd0, ls > rs};
			OP_LT:   alu = {31'd0, ls < rs};
			OP_GE:   alu = {31'd0, ls >= rs};
			OP_LE:   alu = {31'd0, ls <= rs};
			OP_AND:  alu = {31'd0, (sec_q != 0) && (top_q != 0)};
			OP_OR:   alu = {31'd0, (sec_q != 0) || (top_q != 0)};
			default: alu = drsp.result;
		endcase
	end

	always_comb begin
		x_fault = FLT_NONE;
		x_sp    = sp_q;
		x_cd    = cd_q;
		x_next  = pc_next1;
		x_pv    = 1'b0;
		x_pk    = 2'd0;
		x_end   = 1'b0;
		x_we    = 1'b0;
		x_waddr = SA_W'(sp_q);
		x_wdata = arg_q;
		x_cwe   = 1'b0;
		case (op_q)
			OP_SHIFT: begin
				if (arg_q[31]) x_fault = FLT_UNDER;
				else if (arg_s > 34'(STACK_DEPTH)) x_fault = FLT_OVER;
				else x_sp = SP_W'(arg_q);
			end
			OP_PUSH: begin
				if (sp_s >= 34'(STACK_DEPTH)) x_fault = FLT_OVER;
				else begin
					x_we = 1'b1;
					x_sp = sp_q + SP_W'(1);
				end
			end
			OP_LOAD: begin
				if (idx_load < 0 || idx_load >= sp_s) x_fault = FLT_UNDER;
				else if (sp_s >= 34'(STACK_DEPTH)) x_fault = FLT_OVER;
				else begin
					x_we    = 1'b1;
					x_wdata = sec_q;
					x_sp    = sp_q + SP_W'(1);
				end
			end
			OP_STORE: begin
				if (arg_q != 0) begin
					if (sp_q == 0) x_fault = FLT_UNDER;
					else if (idx_store < 0 || idx_store >= sp_s - 34'sd1)
						x_fault = FLT_UNDER;
					else begin
						x_we    = 1'b1;
						x_waddr = idx_store[SA_W-1:0];
						x_wdata = top_q;
						x_sp    = sp_q - SP_W'(1);
					end
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_NEQ, OP_GT, OP_LT,
			OP_GE, OP_LE, OP_AND, OP_OR: begin
				if (sp_q < SP_W'(2)) x_fault = FLT_UNDER;
				else if ((op_q == OP_DIV || op_q == OP_MOD) && top_q == 0)
					x_fault = FLT_DIV0;
				else begin
					x_we    = 1'b1;
					x_waddr = SA_W'(sp_q - SP_W'(2));
					x_wdata = alu;
					x_sp    = sp_q - SP_W'(1);
				end
			end
			OP_NOT: begin
				if (sp_q == 0) x_fault = FLT_UNDER;
				else begin
					x_we    = 1'b1;
					x_waddr = SA_W'(sp_q - SP_W'(1));
					x_wdata = {31'd0, top_q == 0};
				end
			end
			OP_GOTO: x_next = target;
			OP_CALL: begin
				if (cd_q >= CD_W'(CALL_DEPTH)) x_fault = FLT_CALL;
				else begin
					x_cwe  = 1'b1;
					x_cd   = cd_q + CD_W'(1);
					x_next = target;
				end
			end
			OP_GOTOIF: begin
				if (sp_q == 0) x_fault = FLT_UNDER;
				else begin
					x_sp = sp_q - SP_W'(1);
					if (top_q != 0) x_next = target;
				end
			end
			OP_PRINTI, OP_PRINTB, OP_PRINTS: begin
				if (sp_q == 0) x_fault = FLT_UNDER;
				else begin
					x_sp = sp_q - SP_W'(1);
					x_pv = 1'b1;
					x_pk = 2'(op_q - OP_PRINTI);
				end
			end
			OP_RESUME, OP_RETURN: begin
				if (op_q == OP_RETURN && sp_q == 0) x_fault = FLT_UNDER;
				else if (cd_q == 0) x_fault = FLT_CALL;
				else if (nsp < 0) x_fault = FLT_UNDER;
				else if (nsp > 34'(op_q == OP_RETURN ? STACK_DEPTH - 1 : STACK_DEPTH))
					x_fault = FLT_OVER;
				else begin
					x_cd   = cd_q - CD_W'(1);
					x_next = cs_rret;
					x_sp   = SP_W'(nsp);
					if (op_q == OP_RETURN) begin
						x_we    = 1'b1;
						x_waddr = SA_W'(nsp);
						x_wdata = top_q;
						x_sp    = SP_W'(nsp) + SP_W'(1);
					end
				end
			end
			OP_END: begin
				x_sp  = '0;
				x_cd  = '0;
				x_end = 1'b1;
			end
			default: x_fault = FLT_ILL;
		endcase
	end

	assign ds_we    = (state_q == ST_EXE) && out_free && x_fault == FLT_NONE && x_we &&
		!dreq.start;
	assign ds_waddr = x_waddr;
	assign ds_wdata = x_wdata;
	assign cs_we    = (state_q == ST_EXE) && out_free && x_fault == FLT_NONE && x_cwe;
	assign cs_waddr = cd_q[CA_W-1:0];

	assign dreq.start    = (state_q == ST_EXE) && (op_q == OP_DIV || op_q == OP_MOD) &&
		sp_q >= SP_W'(2) && top_q != 0;
	assign dreq.is_mod   = (op_q == OP_MOD);
	assign dreq.dividend = sec_q;
	assign dreq.divisor  = top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			sp_q     <= '0;
			cd_q     <= '0;
			pc_q     <= '0;
			halt_q   <= 1'b0;
			fault_q  <= FLT_NONE;
			len_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				len_q <= cfg_data;
			if (out_load)
				ovalid_q <= 1'b1;
			else if (!out_stall)
				ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (halt_q || 16'(pc_q) >= len_q) begin
							halt_q  <= 1'b1;
							state_q <= ST_OUT;
						end else
							state_q <= ST_RD1;
					end
				end
				ST_RD1: state_q <= ST_RD2;
				ST_RD2: state_q <= ST_EXE;
				ST_EXE: begin
					if (dreq.start)
						state_q <= ST_DIV;
					else if (out_free) begin
						state_q  <= ST_IDLE;
						if (x_fault != FLT_NONE) begin
							halt_q  <= 1'b1;
							fault_q <= x_fault;
						end else begin
							sp_q <= x_sp;
							cd_q <= x_cd;
							pc_q <= x_next;
							if (x_end || 16'(x_next) >= len_q)
								halt_q <= 1'b1;
						end
					end
				end
				ST_DIV: if (drsp.done) state_q <= ST_EXE;
				ST_OUT: begin
					if (out_free)
						state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// operand capture; divide re-enters execute with result ready
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= func;
			arg_q <= argument;
		end
		if (state_q == ST_RD1) top_q <= ds_rdata;
		if (state_q == ST_RD2) sec_q <= ds_rdata;
		if (state_q == ST_DIV && drsp.done) op_q <= (op_q == OP_DIV) ? OP_ADD : OP_ADD;
		if (state_q == ST_DIV && drsp.done) begin
			sec_q <= drsp.result;
			top_q <= '0;
		end
		if (state_q == ST_EXE && out_free && !dreq.start) begin
			onpc_q   <= 16'(x_fault != FLT_NONE ? pc_q : x_next);
			opv_q    <= x_fault == FLT_NONE && x_pv;
			opk_q    <= x_fault == FLT_NONE ? x_pk : 2'd0;
			opval_q  <= (x_fault == FLT_NONE && x_pv) ? top_q : 32'd0;
			ohalt_q  <= x_fault != FLT_NONE || x_end || 16'(x_next) >= len_q;
			ofault_q <= x_fault != FLT_NONE ? x_fault : fault_q;
		end
		if (state_q == ST_OUT && out_free) begin
			onpc_q   <= 16'(pc_q);
			opv_q    <= 1'b0;
			opk_q    <= 2'd0;
			opval_q  <= '0;
			ohalt_q  <= 1'b1;
			ofault_q <= fault_q;
		end
	end

	assign out_valid   = ovalid_q;
	assign next_pc     = onpc_q;
	assign print_valid = opv_q;
	assign print_kind  = opk_q;
	assign print_value = signed'(opval_q);
	assign halted      = ohalt_q;
	assign fault_code  = ofault_q;

	chk_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt cleared");
	chk_fault_halts: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q != FLT_NONE |-> halt_q)
		else $error("fault without halt");
	chk_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer out of range");
	chk_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall)
		else $error("accept while busy");
endmodule
`default_nettype wire
